// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define OSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define OSR_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/osr_pkg.sv
// types, constants and arithmetic helpers for the rotated stiffness block
package osr_pkg;

  localparam int FRAC = 16;
  localparam int QW = 40 + FRAC + 1;
  localparam logic [63:0] HALF = 64'd1 << (FRAC - 1);
  localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [30:0] ONE30 = 31'd1 << 30;
  localparam logic [30:0] RAD36 = 31'd1199381129;
  localparam int FULL = 360 << FRAC;
  localparam int OCT = 45 << FRAC;

  // reciprocals for the series divisions, exact for values below 2^31
  localparam int RSH = 38;
  localparam logic [63:0] R72 = ((64'd1 << RSH) + 64'd71) / 64'd72;
  localparam logic [63:0] R42 = ((64'd1 << RSH) + 64'd41) / 64'd42;
  localparam logic [63:0] R20 = ((64'd1 << RSH) + 64'd19) / 64'd20;
  localparam logic [63:0] R6 = ((64'd1 << RSH) + 64'd5) / 64'd6;
  localparam logic [63:0] R90 = ((64'd1 << RSH) + 64'd89) / 64'd90;
  localparam logic [63:0] R56 = ((64'd1 << RSH) + 64'd55) / 64'd56;
  localparam logic [63:0] R30 = ((64'd1 << RSH) + 64'd29) / 64'd30;
  localparam logic [63:0] R12 = ((64'd1 << RSH) + 64'd11) / 64'd12;

  // octant folding tables, one bit per octant
  localparam logic [7:0] OCT_SWAP = 8'b0110_0110;
  localparam logic [7:0] OCT_CNEG = 8'b0011_1100;

  // pipeline stage numbers of the back end
  localparam int ST_NU2 = 0;
  localparam int ST_DEN = 1;
  localparam int ST_DPREP = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_TRIG = 3;
  localparam int ST_TE = ST_TRIG + 9;
  localparam int ST_DMUL = ST_DIV0 + QW;
  localparam int ST_D0A = ST_DMUL + 1;
  localparam int ST_D0 = ST_D0A + 1;
  localparam int ST_DT0 = ST_D0 + 1;
  localparam int ST_DM0 = ST_DT0 + 6;
  localparam int ST_OUT = ST_DM0 + 6;
  localparam int NSTG = ST_OUT + 1;

  // row and column of each upper-triangle result
  localparam int RI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int CJ [6] = '{0, 1, 2, 1, 2, 2};

  // classified item between front and back
  typedef struct packed {
    logic [39:0] r1;
    logic [39:0] r2;
    logic [15:0] nu;
    logic [39:0] g;
    logic [16:0] beta;
    logic [2:0]  k;
    logic [21:0] u;
    logic        nz;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qport_t;

  // everything one item carries down the back pipeline
  typedef struct packed {
    item_t               it;
    logic                sat;
    logic [16:0]         nu2;
    logic signed [41:0]  den;
    logic [40:0]         dmag;
    logic [QW-1:0]       numer;
    logic [QW-1:0]       quo;
    logic [41:0]         rem;
    logic [40:0]         nu1;
    logic [40:0]         bg;
    logic [30:0]         x;
    logic [30:0]         x2;
    logic [30:0]         ts;
    logic [30:0]         tc;
    logic [30:0]         ms;
    logic [30:0]         mc;
    logic [30:0]         sb;
    logic [30:0]         cb;
    logic signed [63:0]  dmul;
    logic [8:0][32:0]    te;
    logic [2:0][73:0]    dlo;
    logic [8:0][63:0]    d0;
    logic [8:0][73:0]    plo;
    logic [8:0][63:0]    dt;
    logic [5:0][63:0]    dm;
    logic [5:0][47:0]    res;
  } work_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] v;
  } mres_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] v;
  } sres_t;

  // round(a*b / 2^sh), saturating
  function automatic mres_t umulsh(logic [63:0] a, logic [63:0] b, int sh);
    mres_t r;
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    r.sat = (p > 128'(LIM));
    r.v = r.sat ? 64'(LIM) : p[63:0];
    return r;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // low limb of a magnitude times both limbs of b
  function automatic logic [73:0] prod_lo(logic [63:0] a, logic [41:0] b);
    return 74'(64'(a[30:0]) * 64'(b[20:0])) + (74'(64'(a[30:0]) * 64'(b[41:21])) << 21);
  endfunction

  // high limb of a added in, then round(a*b / 2^sh) with saturation and sign
  function automatic sres_t prod_hi(logic [73:0] lo, logic [63:0] a, logic [41:0] b,
                                    logic neg, int sh);
    sres_t r;
    logic [127:0] p;
    logic [63:0] m;
    p = 128'(lo) + (128'(64'(a[63:31]) * 64'(b[20:0])) << 31)
        + (128'(64'(a[63:31]) * 64'(b[41:21])) << 52);
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    r.sat = (p > 128'(LIM));
    m = r.sat ? 64'(LIM) : p[63:0];
    r.v = neg ? -$signed(m) : $signed(m);
    return r;
  endfunction

  function automatic sres_t sadd(logic signed [63:0] a, logic signed [63:0] b);
    sres_t r;
    logic signed [63:0] s;
    s = a + b;
    r.sat = 1'b0;
    r.v = s;
    if (s > LIM) begin
      r.sat = 1'b1;
      r.v = LIM;
    end else if (s < -LIM) begin
      r.sat = 1'b1;
      r.v = -LIM;
    end
    return r;
  endfunction

  // Q.30 product with rounding
  function automatic logic [30:0] mulq(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(ONE30 >> 1);
    return 31'(p >> 30);
  endfunction

  // floor(v / d) through the reciprocal of d
  function automatic logic [30:0] rc(logic [30:0] v, logic [63:0] m);
    logic [66:0] p;
    p = 67'(v) * 67'(m[35:0]);
    return 31'(p >> RSH);
  endfunction

  // combinational work of one back-end stage
  function automatic work_t stage_fn(work_t w, int idx);
    work_t o;
    mres_t mu;
    sres_t sp;
    sres_t sa;
    logic [41:0] rr;
    logic [40:0] dm;
    logic [63:0] q;
    logic [30:0] sbs;
    logic [30:0] cbs;
    logic [30:0] cc;
    logic [30:0] ss;
    logic [30:0] csm;
    logic signed [32:0] cs;
    logic neg;
    logic signed [63:0] v;
    logic [63:0] am;
    logic [41:0] bm;
    logic [63:0] dmg;
    int n;
    int ph;
    o = w;
    n = 0;
    ph = 0;
    // multiplier denominator, angle in radians
    if (idx == ST_NU2) begin
      o.nu2 = 17'((33'(w.it.nu) * 33'(w.it.nu) + 33'(HALF)) >> FRAC);
      o.x = 31'((54'(w.it.u) * 54'(RAD36) + (54'd1 << (FRAC + 5))) >> (FRAC + 6));
    end
    if (idx == ST_DEN) begin
      mu = umulsh(64'(w.nu2), 64'(w.it.r1), FRAC);
      o.den = $signed({2'b00, w.it.r2}) - $signed(42'(mu.v));
      o.sat = w.sat | (w.it.nz & mu.sat);
      o.x2 = mulq(w.x, w.x);
      o.nu1 = 41'((57'(w.it.nu) * 57'(w.it.r1) + 57'(HALF)) >> FRAC);
      o.bg = 41'((58'(w.it.beta) * 58'(w.it.g) + 58'(HALF)) >> FRAC);
    end
    if (idx == ST_DPREP) begin
      dm = w.den[41] ? 41'(-w.den) : 41'(w.den);
      o.dmag = dm;
      o.numer = (QW'(w.it.r2) << FRAC) + QW'(dm >> 1);
      o.rem = '0;
      o.quo = '0;
    end
    // one quotient bit a stage
    if (idx >= ST_DIV0 && idx < ST_DIV0 + QW) begin
      rr = {w.rem[40:0], w.numer[QW-1]};
      o.numer = w.numer << 1;
      if (rr >= {1'b0, w.dmag}) begin
        o.rem = rr - {1'b0, w.dmag};
        o.quo = {w.quo[QW-2:0], 1'b1};
      end else begin
        o.rem = rr;
        o.quo = {w.quo[QW-2:0], 1'b0};
      end
    end
    // Horner series for sine and cosine
    if (idx == ST_TRIG) begin
      o.ts = ONE30 - rc(w.x2, R72);
      o.tc = ONE30 - rc(w.x2, R90);
    end
    if (idx == ST_TRIG + 1 || idx == ST_TRIG + 3 || idx == ST_TRIG + 5) begin
      o.ms = mulq(w.x2, w.ts);
      o.mc = mulq(w.x2, w.tc);
    end
    if (idx == ST_TRIG + 2) begin
      o.ts = ONE30 - rc(w.ms, R42);
      o.tc = ONE30 - rc(w.mc, R56);
    end
    if (idx == ST_TRIG + 4) begin
      o.ts = ONE30 - rc(w.ms, R20);
      o.tc = ONE30 - rc(w.mc, R30);
    end
    if (idx == ST_TRIG + 6) begin
      o.ts = ONE30 - rc(w.ms, R6);
      o.tc = ONE30 - rc(w.mc, R12);
    end
    if (idx == ST_TRIG + 7) begin
      o.ms = mulq(w.x, w.ts);
      o.mc = mulq(w.x2, w.tc);
    end
    if (idx == ST_TRIG + 8) begin
      o.sb = w.ms;
      o.cb = ONE30 - (w.mc >> 1);
    end
    // unfold the octant and build the strain transformation
    if (idx == ST_TE) begin
      sbs = OCT_SWAP[w.it.k] ? w.cb : w.sb;
      cbs = OCT_SWAP[w.it.k] ? w.sb : w.cb;
      cc = mulq(cbs, cbs);
      ss = mulq(sbs, sbs);
      csm = mulq(cbs, sbs);
      neg = (OCT_CNEG[w.it.k] && cbs != '0) != (w.it.k[2] && sbs != '0);
      cs = neg ? -$signed(33'(csm)) : $signed(33'(csm));
      o.te[0] = 33'(cc);
      o.te[1] = 33'(ss);
      o.te[2] = cs;
      o.te[3] = 33'(ss);
      o.te[4] = 33'(cc);
      o.te[5] = -cs;
      o.te[6] = -(cs <<< 1);
      o.te[7] = cs <<< 1;
      o.te[8] = $signed(33'(cc)) - $signed(33'(ss));
    end
    // signed multiplier from the quotient
    if (idx == ST_DMUL) begin
      q = 64'(w.quo);
      if (!w.it.nz) begin
        o.dmul = '0;
      end else if (w.den == '0) begin
        o.sat = 1'b1;
        o.dmul = LIM;
      end else begin
        o.dmul = w.den[41] ? -$signed(q) : $signed(q);
      end
    end
    // local matrix, low limb of the multiplier first
    if (idx == ST_D0A) begin
      dmg = mag(w.dmul);
      o.dlo[0] = prod_lo(dmg, 42'(w.it.r1));
      o.dlo[1] = prod_lo(dmg, 42'(w.nu1));
      o.dlo[2] = prod_lo(dmg, 42'(w.it.r2));
    end
    if (idx == ST_D0) begin
      dmg = mag(w.dmul);
      o.d0 = '0;
      sp = prod_hi(w.dlo[0], dmg, 42'(w.it.r1), w.dmul[63], FRAC);
      o.d0[0] = sp.v;
      o.sat = o.sat | sp.sat;
      sp = prod_hi(w.dlo[1], dmg, 42'(w.nu1), w.dmul[63], FRAC);
      o.d0[1] = sp.v;
      o.d0[3] = sp.v;
      o.sat = o.sat | sp.sat;
      sp = prod_hi(w.dlo[2], dmg, 42'(w.it.r2), w.dmul[63], FRAC);
      o.d0[4] = sp.v;
      o.sat = o.sat | sp.sat;
      o.d0[8] = 64'(w.bg);
    end
    // Te^T * D0, one term of the sum every two stages
    if (idx >= ST_DT0 && idx < ST_DT0 + 6) begin
      n = (idx - ST_DT0) >> 1;
      ph = (idx - ST_DT0) & 1;
      for (int e = 0; e < 9; e++) begin
        am = mag($signed(w.d0[n*3 + e%3]));
        bm = 42'(mag(64'($signed(w.te[n*3 + e/3]))));
        if (ph == 0) begin
          o.plo[e] = prod_lo(am, bm);
        end else begin
          sp = prod_hi(w.plo[e], am, bm, w.te[n*3 + e/3][32] != w.d0[n*3 + e%3][63], 30);
          sa = sadd((n == 0) ? 64'sd0 : $signed(w.dt[e]), sp.v);
          o.dt[e] = sa.v;
          o.sat = o.sat | sp.sat | sa.sat;
        end
      end
    end
    // times Te, upper triangle only
    if (idx >= ST_DM0 && idx < ST_DM0 + 6) begin
      n = (idx - ST_DM0) >> 1;
      ph = (idx - ST_DM0) & 1;
      for (int e = 0; e < 6; e++) begin
        am = mag($signed(w.dt[RI[e]*3 + n]));
        bm = 42'(mag(64'($signed(w.te[n*3 + CJ[e]]))));
        if (ph == 0) begin
          o.plo[e] = prod_lo(am, bm);
        end else begin
          sp = prod_hi(w.plo[e], am, bm, w.dt[RI[e]*3 + n][63] != w.te[n*3 + CJ[e]][32], 30);
          sa = sadd((n == 0) ? 64'sd0 : $signed(w.dm[e]), sp.v);
          o.dm[e] = sa.v;
          o.sat = o.sat | sp.sat | sa.sat;
        end
      end
    end
    // clamp to the output range
    if (idx == ST_OUT) begin
      for (int e = 0; e < 6; e++) begin
        v = $signed(w.dm[e]);
        if (v > OUT_MAX) begin
          v = OUT_MAX;
          o.sat = 1'b1;
        end
        if (v < OUT_MIN) begin
          v = OUT_MIN;
          o.sat = 1'b1;
        end
        o.res[e] = v[47:0];
      end
    end
    return o;
  endfunction

endpackage

// File: src/osr_front.sv
// input stage: takes a transaction, folds the angle into an octant, flags zero stiffness
module osr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // stiff_one, stiff_two, poisson, shear_modulus, shear_factor, angle_deg, zero pad
  input  logic [183:0]           s_tdata,
  output osr_pkg::qport_t        wr,
  input  logic                   full
);

  logic            fv;
  osr_pkg::item_t  fitem;
  osr_pkg::item_t  item_next;
  logic signed [26:0] a;
  logic signed [26:0] d;
  logic [24:0]     dd;
  logic [24:0]     r;
  logic [2:0]      k;

  // angle reduction to 0..360 and octant split
  always_comb begin
    a = 27'($signed(s_tdata[178:153]));
    if (a >= 27'(osr_pkg::FULL)) begin
      d = a - 27'(osr_pkg::FULL);
    end else if (a >= 27'sd0) begin
      d = a;
    end else if (a >= -27'(osr_pkg::FULL)) begin
      d = a + 27'(osr_pkg::FULL);
    end else begin
      d = a + 27'(2 * osr_pkg::FULL);
    end
    dd = d[24:0];
    k = 3'd0;
    for (int j = 1; j < 8; j++) begin
      if (dd >= 25'(j * osr_pkg::OCT)) k = 3'(j);
    end
    r = dd - 25'(k * osr_pkg::OCT);
    item_next.r1 = s_tdata[39:0];
    item_next.r2 = s_tdata[79:40];
    item_next.nu = s_tdata[95:80];
    item_next.g = s_tdata[135:96];
    item_next.beta = s_tdata[152:136];
    item_next.k = k;
    item_next.u = k[0] ? 22'(25'(osr_pkg::OCT) - r) : 22'(r);
    item_next.nz = (s_tdata[39:0] != '0) || (s_tdata[79:40] != '0);
  end

  assign s_tready = !fv || !full;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      fitem <= item_next;
    end
  end

  assign wr.valid = fv && !full;
  assign wr.item = fitem;

endmodule

// File: src/osr_queue.sv
// four-entry queue between the front and the arithmetic pipeline
module osr_queue (
  input  logic            clk,
  input  logic            rst,
  input  osr_pkg::qport_t wr,
  output logic            full,
  output osr_pkg::qport_t rd,
  input  logic            pop
);

  osr_pkg::item_t mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] cnt;
  logic       do_pop;

  assign full = (cnt == 3'd4);
  assign do_pop = pop && (cnt != 3'd0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (wr.valid) wptr <= wptr + 2'd1;
      if (do_pop) rptr <= rptr + 2'd1;
      cnt <= cnt + 3'(wr.valid) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wptr] <= wr.item;
    end
  end

  assign rd.valid = (cnt != 3'd0);
  assign rd.item = mem[rptr];

endmodule

// File: src/osr_back.sv
// arithmetic pipeline: multiplier with divider, sine and cosine, two matrix products
module osr_back (
  input  logic            clk,
  input  logic            rst,
  input  osr_pkg::qport_t rd,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  // d_xx, d_xy, d_xs, d_yy, d_ys, d_ss
  output logic [287:0]    m_tdata,
  // saturated
  output logic            m_tuser
);

  osr_pkg::work_t pipe [osr_pkg::NSTG];
  osr_pkg::work_t w0;
  logic [osr_pkg::NSTG-1:0] vld;
  logic en;

  // the whole pipe moves unless the last stage is held
  assign en = !vld[osr_pkg::NSTG-1] || m_tready;
  assign pop = en;

  always_comb begin
    w0 = '0;
    w0.it = rd.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[osr_pkg::NSTG-2:0], rd.valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= osr_pkg::stage_fn(w0, 0);
      for (int i = 1; i < osr_pkg::NSTG; i++) begin
        pipe[i] <= osr_pkg::stage_fn(pipe[i-1], i);
      end
    end
  end

  assign m_tvalid = vld[osr_pkg::NSTG-1];
  assign m_tdata = pipe[osr_pkg::NSTG-1].res;
  assign m_tuser = pipe[osr_pkg::NSTG-1].sat;

endmodule

// File: src/orthotropic_stiffness_rotate_top.sv
// Rotated orthotropic plane stiffness: one material point in, six matrix entries out.
// A new point is taken every cycle and results leave one per cycle while the output is not
// stalled; an input point passes through the front register, the queue, then 76 pipeline
// stages, whose depth is set mainly by the one-bit-per-stage quotient of the local
// multiplier R2/(R2-nu^2*R1) and by the two-stage split of every wide matrix product.
// Stalls at the output hold the pipeline, and the four-entry queue keeps accepting input
// meanwhile until it is full. m_tuser is high when the denominator was zero for a nonzero
// stiffness or any intermediate or output value clamped.
module orthotropic_stiffness_rotate_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // stiff_one, stiff_two, poisson, shear_modulus, shear_factor, angle_deg, zero pad
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // d_xx, d_xy, d_xs, d_yy, d_ys, d_ss
  output logic [287:0] m_tdata,
  // saturated
  output logic         m_tuser
);

  osr_pkg::qport_t wr;
  osr_pkg::qport_t rd;
  logic full;
  logic pop;

  osr_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .wr, .full
  );

  osr_queue u_queue (
    .clk, .rst, .wr, .full, .rd, .pop
  );

  osr_back u_back (
    .clk, .rst, .rd, .pop, .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule

// File: src/osr_checker.sv
// port-level checks for the rotated stiffness block
`include "assert_macros.svh"

module osr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [287:0] m_tdata,
  input logic         m_tuser
);

  logic [7:0] inflight;

  // transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
    end
  end

  `OSR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `OSR_ASSERT(a_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `OSR_ASSERT(a_no_extra, m_tvalid |-> inflight != 8'd0, "result without a pending input")
  `OSR_ASSERT_NR(a_reset, $past(rst) |-> !m_tvalid, "result shown right after reset")

endmodule

bind orthotropic_stiffness_rotate_top osr_checker u_chk (.*);

// File: bench/tb.sv
// testbench for the rotated orthotropic plane stiffness block
`timescale 1ns / 1ps

module tb;

  localparam longint SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint ENTRY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ENTRY_MIN = -64'sh0000_8000_0000_0000;
  localparam logic [63:0] RAD_Q36 = 64'd1199381129;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [287:0] entries;
    logic         clamped;
  } matrix_t;

  typedef struct {
    logic [39:0] r1;
    logic [39:0] r2;
    logic [15:0] nu;
    logic [39:0] g;
    logic [16:0] beta;
    logic [25:0] phi;
    bit          typed;
    matrix_t     want;
  } point_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [183:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic         m_tuser;

  matrix_t pending_results[$];
  bit      clamp_seen;
  int      errors;
  int      tx_idle;
  int      rx_idle;
  int      accepted;
  int      hold_at;
  int      hold_cnt;
  bit      hold_done;

  orthotropic_stiffness_rotate_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // rounded product a*b / 2^sh with clamp at the intermediate limit
  function automatic logic [63:0] round_prod(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > 128'(SAT_LIM)) begin
      clamp_seen = 1'b1;
      return 64'(SAT_LIM);
    end
    return p[63:0];
  endfunction

  function automatic longint signed_prod(longint a, longint b, int sh);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    m = round_prod(ma, mb, sh);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SAT_LIM) begin
      clamp_seen = 1'b1;
      return SAT_LIM;
    end
    if (s < -SAT_LIM) begin
      clamp_seen = 1'b1;
      return -SAT_LIM;
    end
    return s;
  endfunction

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (UNIT_Q30 >> 1)) >> 30;
  endfunction

  // expected global matrix for one material point
  function automatic matrix_t stiffness_prediction(point_t pt);
    matrix_t res;
    logic [63:0] r1, r2, nu, g, beta, nu2, dmag, quo, u, x, x2, t, sb, cb, tmp;
    longint den, mult, ang, red, rem, sgn_s, sgn_c, cc, ss, cs, acc, v;
    longint d0[3][3];
    longint te[3][3];
    longint dt[3][3];
    longint dm[3][3];
    int k;
    int ri[6];
    int cj[6];
    ri = '{0, 0, 0, 1, 1, 2};
    cj = '{0, 1, 2, 1, 2, 2};
    clamp_seen = 1'b0;
    r1 = 64'(pt.r1);
    r2 = 64'(pt.r2);
    nu = 64'(pt.nu);
    g = 64'(pt.g);
    beta = 64'(pt.beta);
    ang = longint'($signed(pt.phi));
    mult = 0;
    // local multiplier R2/(R2 - nu^2 R1)
    if (r1 + r2 != 0) begin
      nu2 = (nu * nu + 64'd32768) >> 16;
      den = longint'(r2) - longint'(round_prod(nu2, r1, 16));
      if (den == 0) begin
        clamp_seen = 1'b1;
        mult = SAT_LIM;
      end else begin
        dmag = (den < 0) ? 64'(-den) : 64'(den);
        quo = ((r2 << 16) + dmag / 2) / dmag;
        if (quo > 64'(SAT_LIM)) begin
          clamp_seen = 1'b1;
          quo = 64'(SAT_LIM);
        end
        mult = (den < 0) ? -longint'(quo) : longint'(quo);
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        d0[i][j] = 0;
    d0[0][0] = signed_prod(mult, longint'(r1), 16);
    d0[0][1] = signed_prod(mult, longint'((nu * r1 + 64'd32768) >> 16), 16);
    d0[1][0] = d0[0][1];
    d0[1][1] = signed_prod(mult, longint'(r2), 16);
    d0[2][2] = longint'((beta * g + 64'd32768) >> 16);
    // fold the angle into the first octant
    red = ang % (longint'(360) << 16);
    if (red < 0) red = red + (longint'(360) << 16);
    k = int'(red / (longint'(45) << 16));
    rem = red - longint'(k) * (longint'(45) << 16);
    u = 64'((k % 2 == 1) ? (longint'(45) << 16) - rem : rem);
    x = (u * RAD_Q36 + (64'd1 << 21)) >> 22;
    x2 = q30_mul(x, x);
    t = UNIT_Q30 - x2 / 72;
    t = UNIT_Q30 - q30_mul(x2, t) / 42;
    t = UNIT_Q30 - q30_mul(x2, t) / 20;
    t = UNIT_Q30 - q30_mul(x2, t) / 6;
    sb = q30_mul(x, t);
    t = UNIT_Q30 - x2 / 90;
    t = UNIT_Q30 - q30_mul(x2, t) / 56;
    t = UNIT_Q30 - q30_mul(x2, t) / 30;
    t = UNIT_Q30 - q30_mul(x2, t) / 12;
    cb = UNIT_Q30 - q30_mul(x2, t) / 2;
    if (k == 1 || k == 2 || k == 5 || k == 6) begin
      tmp = sb;
      sb = cb;
      cb = tmp;
    end
    sgn_s = (k >= 4) ? -longint'(sb) : longint'(sb);
    sgn_c = (k >= 2 && k <= 5) ? -longint'(cb) : longint'(cb);
    cc = longint'(q30_mul(cb, cb));
    ss = longint'(q30_mul(sb, sb));
    cs = longint'(q30_mul(cb, sb));
    if ((sgn_c < 0) != (sgn_s < 0)) cs = -cs;
    te[0] = '{cc, ss, cs};
    te[1] = '{ss, cc, -cs};
    te[2] = '{-2 * cs, 2 * cs, cc - ss};
    // Te^T * D0 * Te
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int n = 0; n < 3; n++)
          acc = clamp_sum(acc, signed_prod(te[n][i], d0[n][j], 30));
        dt[i][j] = acc;
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int n = 0; n < 3; n++)
          acc = clamp_sum(acc, signed_prod(dt[i][n], te[n][j], 30));
        dm[i][j] = acc;
      end
    for (int n = 0; n < 6; n++) begin
      v = dm[ri[n]][cj[n]];
      if (v > ENTRY_MAX) begin
        v = ENTRY_MAX;
        clamp_seen = 1'b1;
      end
      if (v < ENTRY_MIN) begin
        v = ENTRY_MIN;
        clamp_seen = 1'b1;
      end
      res.entries[n*48 +: 48] = v[47:0];
    end
    res.clamped = clamp_seen;
    return res;
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // random point: mostly realistic material data, some raw bit patterns
  function automatic point_t random_point();
    point_t pt;
    int sel;
    sel = $urandom_range(0, 99);
    pt.typed = 1'b0;
    pt.want = '0;
    if (sel < 70) begin
      pt.r1 = 40'($urandom) << $urandom_range(0, 8);
      pt.r2 = (sel < 5) ? 40'd0 : 40'($urandom) << $urandom_range(0, 8);
      pt.nu = 16'($urandom_range(0, 32768));
      pt.g = 40'($urandom) << $urandom_range(0, 8);
      pt.beta = 17'($urandom_range(0, 65536));
      pt.phi = 26'($signed($urandom_range(0, 47185920)) - 23592960);
    end else begin
      pt.r1 = rand40();
      pt.r2 = rand40();
      pt.nu = 16'($urandom);
      pt.g = rand40();
      pt.beta = 17'($urandom);
      pt.phi = 26'($urandom);
    end
    return pt;
  endfunction

  function automatic point_t mk(logic [39:0] r1, logic [39:0] r2, logic [15:0] nu,
                                logic [39:0] g, logic [16:0] beta, int phi, bit typed);
    point_t pt;
    pt.r1 = r1;
    pt.r2 = r2;
    pt.nu = nu;
    pt.g = g;
    pt.beta = beta;
    pt.phi = 26'(phi);
    pt.typed = typed;
    pt.want = '0;
    return pt;
  endfunction

  // one input transaction, records the expected result on acceptance
  task automatic send_point(point_t pt);
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, pt.phi, pt.beta, pt.g, pt.nu, pt.r2, pt.r1};
    do @(posedge clk); while (!s_tready);
    accepted++;
    pending_results.push_back(pt.typed ? pt.want : stiffness_prediction(pt));
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // receiver readiness and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && hold_at > 0 && accepted >= hold_at) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // output transaction check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        matrix_t w;
        w = pending_results.pop_front();
        for (int n = 0; n < 6; n++)
          if (m_tdata[n*48 +: 48] !== w.entries[n*48 +: 48]) begin
            $display("%0t entry %0d expected %h actual %h", $time, n,
                     w.entries[n*48 +: 48], m_tdata[n*48 +: 48]);
            errors++;
          end
        if (m_tuser !== w.clamped) begin
          $display("%0t saturated expected %b actual %b", $time, w.clamped, m_tuser);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    point_t dir[$];
    point_t pt;
    int phase_tx[3];
    int phase_rx[3];
    int phase_n[3];
    phase_tx = '{30, 68, 0};
    phase_rx = '{68, 30, 0};
    phase_n = '{600, 600, 480};
    errors = 0;
    accepted = 0;
    hold_at = 0;
    tx_idle = 0;
    rx_idle = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points: zeros, extremes, octants, zero and negative denominators
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    dir.push_back(mk(0, 0, 32768, 0, 65536, 23592960, 1));
    dir.push_back(mk(0, 0, 16'hFFFF, 40'hFF_FFFF_FFFF, 0, -23592960, 0));
    dir.push_back(mk(40'h10_0000, 0, 0, 40'h8_0000, 65536, 0, 0));
    dir.push_back(mk(40'h10_0000, 40'h10_0000, 0, 40'h4_0000, 65536, 0, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 45 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 90 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 135 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 180 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, -(90 << 16), 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 30 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 300 << 16, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, 23592960, 0));
    dir.push_back(mk(40'h10_0000, 40'h40_0000, 16384, 40'h4_0000, 32768, -23592960, 0));
    dir.push_back(mk(40'h40_0000, 40'h1_0000, 65535, 40'h1_0000, 65536, 12 << 16, 0));
    dir.push_back(mk(40'h40_0000, 40'h10_0000, 32768, 40'h1_0000, 131071, 60 << 16, 0));
    dir.push_back(mk(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 32768, 40'hFF_FFFF_FFFF, 65536,
                     33 << 16, 0));
    dir.push_back(mk(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 40'hFF_FFFF_FFFF,
                     17'h1FFFF, -1, 0));
    dir.push_back(mk(40'hFF_FFFF_FFFF, 40'h1, 0, 0, 0, 1, 0));
    dir.push_back(mk(40'h1, 40'hFF_FFFF_FFFF, 1, 40'h1, 1, 26'h1FF_FFFF, 0));
    dir.push_back(mk(40'h1, 40'h1, 32768, 40'h1, 65536, 26'h200_0000, 0));
    foreach (dir[i]) send_point(dir[i]);
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);

    // random phases with varied idling
    for (int p = 0; p < 3; p++) begin
      tx_idle = phase_tx[p];
      rx_idle = phase_rx[p];
      if (p == 2) hold_at = accepted + 20;
      for (int i = 0; i < phase_n[p]; i++) begin
        maybe_gap();
        pt = random_point();
        send_point(pt);
      end
      s_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      @(posedge clk);
    end

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
